FILE: hw/rtl/tclp_pkg.sv
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared constants, types and character helpers for the command line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

	localparam int LINE_CAPACITY = 48;
	localparam int ADDR_W        = $clog2(LINE_CAPACITY);
	localparam int PCT_W         = 7;
	localparam int IDX_W         = 3;
	localparam int POS_W         = 4;

	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_THREE = 8'd51;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	// action codes
	localparam logic [1:0] ACT_LED_ON  = 2'd0;
	localparam logic [1:0] ACT_LED_OFF = 2'd1;
	localparam logic [1:0] ACT_MOTOR   = 2'd2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [IDX_W-1:0] CFG_GEAR0  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_GEAR1  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_GEAR2  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_GEAR3  = 3'd4;

	localparam logic [POS_W-1:0] LEN_ON    = 4'd6;
	localparam logic [POS_W-1:0] LEN_OFF   = 4'd7;
	localparam logic [POS_W-1:0] POS_DIGIT = 4'd12;
	localparam logic [POS_W-1:0] LEN_MOTOR = 4'd13;
	localparam logic [POS_W-1:0] POS_SAT   = 4'd15;

	typedef struct packed {
		logic store;
		logic line_clr;
		logic scan_start;
		logic scan_read;
		logic emit;
	} tclp_cmd_t;

	typedef struct packed {
		logic nl;
		logic overflow;
		logic len_zero;
		logic scan_last;
		logic hit;
		logic out_free;
	} tclp_sts_t;

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_NL);
	endfunction

	// "led_on"
	function automatic logic on_char_ok(input logic [POS_W-1:0] i, input logic [7:0] c);
		logic [7:0] e;
		e = 8'd0;
		case (i)
			4'd0: e = "l";
			4'd1: e = "e";
			4'd2: e = "d";
			4'd3: e = "_";
			4'd4: e = "o";
			4'd5: e = "n";
			default: e = 8'd0;
		endcase
		on_char_ok = (i < LEN_ON) && (c == e);
	endfunction

	// "led_off"
	function automatic logic off_char_ok(input logic [POS_W-1:0] i, input logic [7:0] c);
		logic [7:0] e;
		e = 8'd0;
		case (i)
			4'd0: e = "l";
			4'd1: e = "e";
			4'd2: e = "d";
			4'd3: e = "_";
			4'd4: e = "o";
			4'd5: e = "f";
			4'd6: e = "f";
			default: e = 8'd0;
		endcase
		off_char_ok = (i < LEN_OFF) && (c == e);
	endfunction

	// motor command word then one gear digit
	function automatic logic motor_char_ok(input logic [POS_W-1:0] i, input logic [7:0] c);
		logic [7:0] e;
		e = 8'd0;
		case (i)
			4'd0:  e = "m";
			4'd1:  e = "o";
			4'd2:  e = "t";
			4'd3:  e = "o";
			4'd4:  e = "r";
			4'd5:  e = "_";
			4'd6:  e = "s";
			4'd7:  e = "p";
			4'd8:  e = "e";
			4'd9:  e = "e";
			4'd10: e = "d";
			4'd11: e = "_";
			default: e = 8'd0;
		endcase
		if (i == POS_DIGIT)
			motor_char_ok = (c >= CHAR_ZERO) && (c <= CHAR_THREE);
		else
			motor_char_ok = (i < POS_DIGIT) && (c == e);
	endfunction

endpackage

FILE: hw/rtl/tclp_ram.sv
// ----------------------------------------------------------------------------
// tclp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tclp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/tclp_ctrl.sv
// ----------------------------------------------------------------------------
// tclp_ctrl
// Sequencer: takes bytes, runs the line-end scan and hands off the result.
// ----------------------------------------------------------------------------
module tclp_ctrl
	import tclp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tclp_sts_t sts,
	output tclp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!sts.nl) begin
						cmd.store = 1'b1;
					end else if (sts.overflow || sts.len_zero) begin
						cmd.line_clr = 1'b1;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_read = 1'b1;
				if (sts.scan_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last read beat lands in the matcher
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.hit) begin
					cmd.line_clr = 1'b1;
					state_d      = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.line_clr = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: hw/rtl/tclp_dp.sv
// ----------------------------------------------------------------------------
// tclp_dp
// Datapath: line store, length and overflow tracking, streaming matcher,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module tclp_dp
	import tclp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       rx_byte,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [PCT_W-1:0] cfg_data,
	input  tclp_cmd_t        cmd,
	output tclp_sts_t        sts,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       action,
	output logic [PCT_W-1:0] speed_percent
);

	localparam logic [ADDR_W-1:0] LEN_LIMIT = ADDR_W'(LINE_CAPACITY - 1);

	logic [ADDR_W-1:0] len_q;
	logic              overflow_q;
	logic [ADDR_W-1:0] raddr_q;
	logic              rvalid_s1;
	logic [7:0]        rdata;
	logic              ram_we;

	logic             enable_q;
	logic [PCT_W-1:0] gear_q [4];

	logic [POS_W-1:0] pos_q;
	logic             on_ok_q;
	logic             off_ok_q;
	logic             mot_ok_q;
	logic             started_q;
	logic             trail_q;
	logic             bad_q;
	logic [1:0]       digit_q;

	logic             out_valid_q;
	logic [1:0]       action_q;
	logic [PCT_W-1:0] speed_q;

	logic             hit_on;
	logic             hit_off;
	logic             hit_mot;
	logic [PCT_W-1:0] gear_pct;
	logic [1:0]       act_d;
	logic [PCT_W-1:0] pct_d;

	assign ram_we = cmd.store && !overflow_q && (len_q != LEN_LIMIT);

	tclp_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CAPACITY)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(len_q),
		.wdata(rx_byte),
		.re   (cmd.scan_read),
		.raddr(raddr_q),
		.rdata(rdata)
	);

	// line length and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.line_clr) begin
			len_q      <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.store && !overflow_q) begin
			if (len_q == LEN_LIMIT) begin
				overflow_q <= 1'b1;
				len_q      <= '0;
			end else begin
				len_q <= len_q + 1'b1;
			end
		end
	end

	// scan address and read beat tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raddr_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.scan_read;
			if (cmd.scan_start)
				raddr_q <= '0;
			else if (cmd.scan_read)
				raddr_q <= raddr_q + 1'b1;
		end
	end

	// streaming matcher: leading blanks skipped, a blank after text starts the
	// trailing run, and any text after that spoils the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			on_ok_q   <= 1'b0;
			off_ok_q  <= 1'b0;
			mot_ok_q  <= 1'b0;
			started_q <= 1'b0;
			trail_q   <= 1'b0;
			bad_q     <= 1'b0;
			digit_q   <= '0;
		end else if (cmd.scan_start) begin
			pos_q     <= '0;
			on_ok_q   <= 1'b1;
			off_ok_q  <= 1'b1;
			mot_ok_q  <= 1'b1;
			started_q <= 1'b0;
			trail_q   <= 1'b0;
			bad_q     <= 1'b0;
		end else if (rvalid_s1) begin
			if (is_blank(rdata)) begin
				if (started_q)
					trail_q <= 1'b1;
			end else begin
				if (trail_q)
					bad_q <= 1'b1;
				started_q <= 1'b1;
				on_ok_q   <= on_ok_q && on_char_ok(pos_q, rdata);
				off_ok_q  <= off_ok_q && off_char_ok(pos_q, rdata);
				mot_ok_q  <= mot_ok_q && motor_char_ok(pos_q, rdata);
				if (pos_q == POS_DIGIT)
					digit_q <= rdata[1:0];
				if (pos_q != POS_SAT)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			gear_q[0] <= 7'd0;
			gear_q[1] <= 7'd33;
			gear_q[2] <= 7'd66;
			gear_q[3] <= 7'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE: enable_q  <= cfg_data[0];
				CFG_GEAR0:  gear_q[0] <= cfg_data;
				CFG_GEAR1:  gear_q[1] <= cfg_data;
				CFG_GEAR2:  gear_q[2] <= cfg_data;
				CFG_GEAR3:  gear_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hit_on   = on_ok_q && (pos_q == LEN_ON);
	assign hit_off  = off_ok_q && (pos_q == LEN_OFF);
	assign hit_mot  = mot_ok_q && (pos_q == LEN_MOTOR);
	assign gear_pct = gear_q[digit_q];

	always_comb begin
		act_d = ACT_LED_ON;
		pct_d = '0;
		if (hit_off) begin
			act_d = ACT_LED_OFF;
		end else if (hit_mot) begin
			act_d = ACT_MOTOR;
			pct_d = (gear_pct > PCT_MAX) ? PCT_MAX : gear_pct;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			action_q <= act_d;
			speed_q  <= pct_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign speed_percent = speed_q;

	assign sts.nl        = (rx_byte == CHAR_NL);
	assign sts.overflow  = overflow_q;
	assign sts.len_zero  = (len_q == '0);
	assign sts.scan_last = (raddr_q == (len_q - 1'b1));
	assign sts.hit       = enable_q && started_q && !bad_q && (hit_on || hit_off || hit_mot);
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

FILE: hw/rtl/text_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// text_command_line_parser_core
// Assembles received bytes into lines and decodes the led on, led off and
// motor gear commands into action beats.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------
//  in      | in_valid / in_stall    | rx_byte[7:0]
//  out     | out_valid / out_stall  | action[1:0], speed_percent[6:0]
//  cfg     | cfg_we                 | cfg_index[2:0], cfg_data[6:0]
//
// a non-newline byte is taken without a stall; a newline on a non-empty line
// starts a scan (one line store read per cycle, then drain and decide)
// empty or overflowed lines are cleared without a scan
// in_stall is high while the scan runs, and while a hit waits for the output
// register to free up; bytes are still taken while a result beat waits
// reset clears length, overflow, the scan state and config to defaults
// ----------------------------------------------------------------------------
module text_command_line_parser_core
	import tclp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       action,
	output logic [PCT_W-1:0] speed_percent,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [PCT_W-1:0] cfg_data
);

	tclp_cmd_t cmd;
	tclp_sts_t sts;

	tclp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	tclp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.speed_percent(speed_percent)
	);

	// a new result only comes out of the decide step, which holds off input
	a_emit_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat rose without a finished scan");

	a_light_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != ACT_MOTOR) |-> (speed_percent == '0))
		else $error("light action carries a speed");

	a_speed_capped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (speed_percent <= PCT_MAX) && (action <= ACT_MOTOR))
		else $error("speed above cap or bad action code");

endmodule

FILE: test/command_decode_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_decode_check
// Watches the byte, action and register ports of the command line parser,
// rebuilds each line from the accepted bytes, decodes it on the newline and
// compares every action beat with the oldest decoded command still due.
// ----------------------------------------------------------------------------
module command_decode_check
	import tclp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [7:0]       rx_byte,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [1:0]       action,
	input  logic [PCT_W-1:0] speed_percent,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [PCT_W-1:0] cfg_data,
	output int               mismatches,
	output int               actions_due
);

	localparam string MOTOR_WORD = {"motor", "_speed_"};

	typedef struct packed {
		logic [1:0]       act;
		logic [PCT_W-1:0] pct;
	} action_beat_t;

	action_beat_t     due_actions[$];
	action_beat_t     oldest;
	logic [7:0]       line_buf [LINE_CAPACITY];
	int               line_len;
	logic             dropping;
	logic             enabled;
	logic [PCT_W-1:0] gear_pct [4];
	int               errors;

	function automatic logic blank_char(input logic [7:0] c);
		return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_NL;
	endfunction

	function automatic logic word_at(input int pos, input string w);
		for (int i = 0; i < w.len(); i++)
			if (line_buf[pos + i] != 8'(w[i]))
				return 1'b0;
		return 1'b1;
	endfunction

	// trim the stored line and look for one of the three commands
	function automatic logic decode_line(output action_beat_t beat);
		int lo;
		int hi;
		logic [7:0] digit;
		logic [PCT_W-1:0] pct;
		lo = 0;
		hi = line_len;
		beat = '0;
		while (lo < hi && blank_char(line_buf[lo]))
			lo++;
		while (hi > lo && blank_char(line_buf[hi - 1]))
			hi--;
		if (hi == lo || !enabled)
			return 1'b0;
		if (hi - lo == 6 && word_at(lo, "led_on")) begin
			beat.act = ACT_LED_ON;
			return 1'b1;
		end
		if (hi - lo == 7 && word_at(lo, "led_off")) begin
			beat.act = ACT_LED_OFF;
			return 1'b1;
		end
		if (hi - lo == 13 && word_at(lo, MOTOR_WORD)) begin
			digit = line_buf[lo + 12];
			if (digit >= CHAR_ZERO && digit <= CHAR_THREE) begin
				pct = gear_pct[2'(digit - CHAR_ZERO)];
				beat.act = ACT_MOTOR;
				beat.pct = (pct > PCT_MAX) ? PCT_MAX : pct;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		action_beat_t beat;
		if (b == CHAR_NL) begin
			if (!dropping && decode_line(beat))
				due_actions.push_back(beat);
			line_len = 0;
			dropping = 1'b0;
		end else if (!dropping) begin
			// the byte that would fill the store drops the whole line
			if (line_len + 1 >= LINE_CAPACITY) begin
				dropping = 1'b1;
				line_len = 0;
			end else begin
				line_buf[line_len] = b;
				line_len++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_actions.delete();
			line_len = 0;
			dropping = 1'b0;
			enabled = 1'b1;
			gear_pct = '{7'd0, 7'd33, 7'd66, 7'd100};
			errors = 0;
			mismatches <= 0;
			actions_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_actions.size() == 0) begin
					errors++;
					$display("%0t: beat with nothing due, got action %0d speed %0d",
						$time, action, speed_percent);
				end else begin
					oldest = due_actions.pop_front();
					if (action !== oldest.act) begin
						errors++;
						$display("%0t: action expected %0d, got %0d", $time, oldest.act, action);
					end
					if (speed_percent !== oldest.pct) begin
						errors++;
						$display("%0t: speed_percent expected %0d, got %0d",
							$time, oldest.pct, speed_percent);
					end
				end
			end
			if (in_valid && !in_stall)
				take_byte(rx_byte);
			if (cfg_we) begin
				case (cfg_index) inside
					CFG_ENABLE: enabled = cfg_data[0];
					CFG_GEAR0, CFG_GEAR1, CFG_GEAR2, CFG_GEAR3: begin
						gear_pct[2'(cfg_index - CFG_GEAR0)] = cfg_data;
					end
					default: ;
				endcase
			end
			mismatches <= errors;
			actions_due <= due_actions.size();
		end
	end

endmodule

FILE: test/tb_text_command_line_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_command_line_parser_core
// Feeds directed command lines, blank and overlong lines, then random mixes
// of well-formed, damaged and noise lines under several register settings,
// with random idle cycles on both channels; the checker scores every beat.
// ----------------------------------------------------------------------------
module tb_text_command_line_parser_core;
	import tclp_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int SCAN_SLACK   = LINE_CAPACITY + 12;
	localparam int RANDOM_BYTES = 456;
	localparam int PHASES       = 6;
	localparam string MOTOR_WORD = {"motor", "_speed_"};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic [7:0]       rx_byte   = 8'd0;
	logic             out_stall = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = CFG_ENABLE;
	logic [PCT_W-1:0] cfg_data  = '0;
	logic             in_stall;
	logic             out_valid;
	logic [1:0]       action;
	logic [PCT_W-1:0] speed_percent;
	int               mismatches;
	int               actions_due;

	logic             steady = 1'b0;
	int               quiet_cycles = 0;
	int               sent_bytes;
	logic [7:0]       line_q[$];
	string            words[3]  = '{"led_on", "led_off", MOTOR_WORD};
	logic [7:0]       blanks[3] = '{CHAR_SPACE, CHAR_TAB, CHAR_CR};

	text_command_line_parser_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.action        (action),
		.speed_percent (speed_percent),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	command_decode_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.action        (action),
		.speed_percent (speed_percent),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.actions_due   (actions_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 10);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sent_bytes++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(8'(s[i]));
	endtask

	// word padded with spaces to a given stored length, then the newline
	task automatic send_padded(input string w, input int total, input logic pad_front);
		if (pad_front)
			repeat (total - w.len()) push_byte(CHAR_SPACE);
		send_text(w);
		if (!pad_front)
			repeat (total - w.len()) push_byte(CHAR_SPACE);
		push_byte(CHAR_NL);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (actions_due != 0);
	endtask

	// a newline that yields nothing may still be scanning, so give it time
	task automatic settle();
		wait_results();
		repeat (SCAN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PCT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_regs(input logic [PCT_W-1:0] en, input logic [PCT_W-1:0] g0,
			input logic [PCT_W-1:0] g1, input logic [PCT_W-1:0] g2,
			input logic [PCT_W-1:0] g3);
		write_reg(CFG_ENABLE, en);
		write_reg(CFG_GEAR0, g0);
		write_reg(CFG_GEAR1, g1);
		write_reg(CFG_GEAR2, g2);
		write_reg(CFG_GEAR3, g3);
		for (int k = CFG_GEAR3 + 1; k < 2 ** IDX_W; k++)
			write_reg(IDX_W'(k), PCT_W'($urandom_range(127)));
		cfg_we <= 1'b0;
	endtask

	task automatic make_line();
		int kind;
		int n;
		int pos;
		string w;
		line_q.delete();
		kind = $urandom_range(99);
		if (kind < 80) begin
			repeat ($urandom_range(3)) line_q.push_back(blanks[$urandom_range(2)]);
			w = words[$urandom_range(2)];
			for (int i = 0; i < w.len(); i++)
				line_q.push_back(8'(w[i]));
			if (w.len() == 12) begin
				if ($urandom_range(7) != 0)
					line_q.push_back(8'(CHAR_ZERO + $urandom_range(3)));
				else
					line_q.push_back(8'($urandom_range(255)));
			end
			repeat ($urandom_range(3)) line_q.push_back(blanks[$urandom_range(2)]);
			// damaged command: one byte changed, dropped or added
			if (kind >= 65) begin
				pos = $urandom_range(line_q.size() - 1);
				case ($urandom_range(2))
					0: line_q[pos] = 8'($urandom_range(255));
					1: line_q.delete(pos);
					default: line_q.insert(pos, 8'($urandom_range(255)));
				endcase
			end
		end else if (kind < 95) begin
			repeat ($urandom_range(20)) line_q.push_back(8'($urandom_range(255)));
		end else begin
			// lengths around the capacity edge
			n = $urandom_range(LINE_CAPACITY - 4, LINE_CAPACITY + 4);
			w = words[$urandom_range(1)];
			repeat ($urandom_range(n - w.len())) line_q.push_back(blanks[$urandom_range(2)]);
			for (int i = 0; i < w.len(); i++)
				line_q.push_back(8'(w[i]));
			while (line_q.size() < n)
				line_q.push_back(blanks[$urandom_range(2)]);
		end
		line_q.push_back(CHAR_NL);
	endtask

	initial begin
		sent_bytes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every command at reset gears, trimming, blank and malformed lines
		send_text("led_on\n");
		send_text("led_off\n");
		send_text({MOTOR_WORD, "0\n"});
		send_text({MOTOR_WORD, "1\n"});
		send_text({MOTOR_WORD, "2\n"});
		send_text({MOTOR_WORD, "3\n"});
		send_text(" \t\015led_off\t \015\n");
		send_text("\n");
		send_text(" \t\015 \n");
		send_text({MOTOR_WORD, "4\n"});
		send_text({MOTOR_WORD, "/\n"});
		send_text({MOTOR_WORD, "\n"});
		send_text({MOTOR_WORD, "12\n"});
		send_text("led_onn\n");
		send_text("led_ on\n");
		send_text("led_o\n");
		// nul and high bytes are stored like any other
		send_text("led_on");
		push_byte(8'h00);
		push_byte(CHAR_NL);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(CHAR_NL);
		// longest line that fits, then one byte too many and a far longer line, then recovery
		send_padded("led_on", LINE_CAPACITY - 1, 1'b0);
		send_padded({MOTOR_WORD, "3"}, LINE_CAPACITY - 1, 1'b1);
		send_padded("led_off", LINE_CAPACITY, 1'b1);
		send_padded("led_on", LINE_CAPACITY + 12, 1'b0);
		send_text("led_off\n");

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			steady <= (ph == 1);
			case (ph)
				0: apply_regs(7'h7E, 7'd127, 7'd101, 7'd100, 7'd0);
				1: apply_regs(7'h01, 7'd127, 7'd101, 7'd100, 7'd0);
				2: apply_regs(7'h7F, 7'd0, 7'd100, 7'd0, 7'd100);
				default: begin
					apply_regs(PCT_W'($urandom_range(3) != 0), PCT_W'($urandom_range(127)),
						PCT_W'($urandom_range(127)), PCT_W'($urandom_range(127)),
						PCT_W'($urandom_range(127)));
				end
			endcase
			sent_bytes = 0;
			while (sent_bytes < RANDOM_BYTES / PHASES) begin
				make_line();
				for (int i = 0; i < line_q.size(); i++)
					push_byte(line_q[i]);
				if ($urandom_range(39) == 0)
					wait_results();
			end
		end

		settle();
		if (mismatches == 0 && actions_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
